// File: design/pdre_pkg.sv
// ---------------------------------------------------------------------------
// pdre_pkg: shared types, constants and control program
// Holds the register map, fixed constants and the microcode table that
// drives the pulse conditioning datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package pdre_pkg;

    // widths of the fixed fields
    localparam int PULSE_IN_W  = 12;
    localparam int PULSE_OUT_W = 11;
    localparam int CENTER_W    = 11;
    localparam int DEAD_W      = 9;
    localparam int GAIN_W      = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int DEV_W       = 13;
    localparam int SPAN_W      = 11;
    localparam int PROD_W      = 23;
    localparam int GAIN_SHIFT  = 16;

    // default fraction bits of the smoothed value
    localparam int DEF_FRAC_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd3;

    // register reset values
    localparam logic [CENTER_W-1:0] CENTER_RESET = 11'd1500;
    localparam logic [DEAD_W-1:0]   DEAD_RESET   = 9'd0;
    localparam logic [GAIN_W-1:0]   GAIN_ONE     = 17'h10000;

    // output limits
    localparam logic [PULSE_OUT_W-1:0] OUT_MIN = 11'd1000;
    localparam logic [PULSE_OUT_W-1:0] OUT_MAX = 11'd2000;

    typedef logic [3:0] step_t;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_DEV,
        OP_SIDE,
        OP_SPAN,
        OP_DIV,
        OP_TGT,
        OP_MULA,
        OP_MULB,
        OP_UPD,
        OP_DEAD,
        OP_OUT
    } op_t;

    // jump conditions: taken goes to target, else to the next step
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_DEAD,
        COND_SMALL,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // program step addresses
    localparam step_t S_IDLE = 4'd0;
    localparam step_t S_DEV  = 4'd1;
    localparam step_t S_SIDE = 4'd2;
    localparam step_t S_SPAN = 4'd3;
    localparam step_t S_DIV  = 4'd4;
    localparam step_t S_TGT  = 4'd5;
    localparam step_t S_MULA = 4'd6;
    localparam step_t S_MULB = 4'd7;
    localparam step_t S_UPD  = 4'd8;
    localparam step_t S_DEAD = 4'd9;
    localparam step_t S_OUT  = 4'd10;
    localparam step_t S_RET  = 4'd11;

    // control program
    function automatic ctrl_t ucode_word(input step_t s);
        ctrl_t w;
        case (s)
            S_IDLE:  w = '{op: OP_IDLE, cond: COND_NO_REQ,   target: S_IDLE};
            S_DEV:   w = '{op: OP_DEV,  cond: COND_NEVER,    target: S_IDLE};
            S_SIDE:  w = '{op: OP_SIDE, cond: COND_DEAD,     target: S_DEAD};
            S_SPAN:  w = '{op: OP_SPAN, cond: COND_SMALL,    target: S_TGT};
            S_DIV:   w = '{op: OP_DIV,  cond: COND_DIV_MORE, target: S_DIV};
            S_TGT:   w = '{op: OP_TGT,  cond: COND_NEVER,    target: S_IDLE};
            S_MULA:  w = '{op: OP_MULA, cond: COND_NEVER,    target: S_IDLE};
            S_MULB:  w = '{op: OP_MULB, cond: COND_NEVER,    target: S_IDLE};
            S_UPD:   w = '{op: OP_UPD,  cond: COND_ALWAYS,   target: S_OUT};
            S_DEAD:  w = '{op: OP_DEAD, cond: COND_NEVER,    target: S_IDLE};
            S_OUT:   w = '{op: OP_OUT,  cond: COND_OUT_BUSY, target: S_OUT};
            S_RET:   w = '{op: OP_NOP,  cond: COND_ALWAYS,   target: S_IDLE};
            default: w = '{op: OP_NOP,  cond: COND_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/pwm_deadband_rescale_ema_unit.sv
// ---------------------------------------------------------------------------
// pwm_deadband_rescale_ema_unit: RC pulse deadband, rescale and smoothing
// Microcoded sequencer over a small datapath: deadband test, side rescale
// by a restoring divider, then an EMA blend on one shared multiplier.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: pulse_in with in_valid / in_stall. A request is taken
//   when in_valid is high and in_stall low; in_stall is low only while the
//   sequencer sits in its idle step.
//   Output channel: pulse_out with out_valid / out_stall, driven from an
//   output register, so a new request is taken while a result waits.
//   Configuration: cfg_write, cfg_index, cfg_data; index 0 center width
//   (also reloads the smoothed value), 1 deadband, 2 gain, 3 mode.
//   Sequence: idle, deviation and side steps, then a deadband hit goes
//   through the dead step to the output step; a throw no wider than the
//   deadband through the target, blend and update steps; any other throw
//   first runs the one-bit-per-cycle divider loop before the target step.
//   Reset clears the registers to their defaults and the smoothed value to
//   center width 1500. A stalled result holds the sequencer in its output
//   step until the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module pwm_deadband_rescale_ema_unit
    import pdre_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [PULSE_IN_W-1:0]  pulse_in,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [PULSE_OUT_W-1:0]      pulse_out
);

    localparam int Q_W   = 12 + FRAC_BITS;
    localparam int NUM_W = PROD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int ACC_W = Q_W + GAIN_W;

    // configuration and state registers
    logic [CENTER_W-1:0]    center_reg;
    logic [DEAD_W-1:0]      dead_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic                   mode_reg;
    logic [Q_W-1:0]         smooth_reg, smooth_next;

    // sequencer
    step_t                  step_reg, step_next;
    ctrl_t                  ctrl;
    logic                   take;

    // datapath registers
    logic [PULSE_IN_W-1:0]  pulse_reg, pulse_next;
    logic signed [DEV_W-1:0] dev_reg, dev_next;
    logic                   upper_reg, upper_next;
    logic [PULSE_IN_W-1:0]  mag_reg, mag_next;
    logic signed [DEV_W-1:0] throw_reg, throw_next;
    logic [SPAN_W-1:0]      span_reg, span_next;
    logic [SPAN_W-1:0]      rem_reg, rem_next;
    logic [NUM_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [Q_W-1:0]         target_reg, target_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [PULSE_OUT_W-1:0] res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PULSE_OUT_W-1:0] out_data_reg, out_data_next;

    // combinational helpers
    logic                   in_accept;
    logic [PULSE_IN_W-1:0]  pulse_eff;
    logic signed [DEV_W-1:0] center_s, dead_s, dev_neg, throw_calc, span_calc;
    logic                   dead_hit, small_throw;
    logic [PULSE_IN_W-1:0]  abs_dev;
    logic [PROD_W-1:0]      prod;
    logic [SPAN_W:0]        trial;
    logic                   trial_ge;
    logic [Q_W-1:0]         center_q;
    logic [NUM_W:0]         up_sum;
    logic [GAIN_W-1:0]      gain_eff, gain_rest;
    logic [GAIN_W-1:0]      mul_a;
    logic [Q_W-1:0]         mul_b;
    logic [ACC_W-1:0]       mul_prod;
    logic [Q_W-1:0]         blended;
    logic [PULSE_IN_W-1:0]  whole;

    assign ctrl      = ucode_word(step_reg);
    assign in_stall  = (step_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign pulse_out = out_data_reg;

    // signed views of the registers
    assign center_s = $signed({2'b00, center_reg});
    assign dead_s   = $signed({4'b0000, dead_reg});
    assign center_q = Q_W'(center_reg) << FRAC_BITS;

    // bottom-anchored clamp and deviation
    assign pulse_eff = (mode_reg && (pulse_reg < PULSE_IN_W'(center_reg)))
                       ? PULSE_IN_W'(center_reg) : pulse_reg;

    // deadband test on the registered deviation
    assign dead_hit = mode_reg ? (dev_reg <= dead_s)
                               : ((dev_reg >= -dead_s) && (dev_reg <= dead_s));

    // magnitude and throw of the active side
    assign dev_neg    = -dev_reg;
    assign abs_dev    = (dev_reg > 0) ? dev_reg[PULSE_IN_W-1:0]
                                      : dev_neg[PULSE_IN_W-1:0];
    assign throw_calc = (dev_reg > 0) ? ($signed({2'b00, OUT_MAX}) - center_s)
                                      : (center_s - $signed({2'b00, OUT_MIN}));

    // span and excess times throw
    assign small_throw = (throw_reg <= dead_s);
    assign span_calc   = throw_reg - dead_s;
    assign prod        = PROD_W'(mag_reg) * PROD_W'(throw_reg[SPAN_W-1:0]);

    // one restoring divide step
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, span_reg});

    // upper side sum before saturation
    assign up_sum = (NUM_W+1)'(quo_reg) + (NUM_W+1)'(center_q);

    // shared blend multiplier
    assign gain_eff  = gain_reg[GAIN_W-1] ? GAIN_ONE : gain_reg;
    assign gain_rest = GAIN_ONE - gain_eff;
    assign mul_a     = (ctrl.op == OP_MULA) ? gain_eff : gain_rest;
    assign mul_b     = (ctrl.op == OP_MULA) ? target_reg : smooth_reg;
    assign mul_prod  = ACC_W'(mul_a) * ACC_W'(mul_b);

    // blended value and its integer part, clamped in the update step
    assign blended = acc_reg[GAIN_SHIFT +: Q_W];
    assign whole   = blended[Q_W-1 -: PULSE_IN_W];

    // jump condition
    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_REQ:   take = !in_accept;
            COND_DEAD:     take = dead_hit;
            COND_SMALL:    take = small_throw;
            COND_DIV_MORE: take = (cnt_reg != '0);
            COND_OUT_BUSY: take = out_valid_reg && out_stall;
            default:       take = 1'b1;
        endcase
        step_next = take ? ctrl.target : step_t'(step_reg + 4'd1);
    end

    // datapath next values
    always_comb
    begin
        pulse_next     = pulse_reg;
        dev_next       = dev_reg;
        upper_next     = upper_reg;
        mag_next       = mag_reg;
        throw_next     = throw_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        target_next    = target_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        smooth_next    = smooth_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (ctrl.op)
            OP_IDLE:
            begin
                if (in_accept)
                    pulse_next = pulse_in;
            end
            OP_DEV:
            begin
                dev_next = $signed({1'b0, pulse_eff}) - center_s;
            end
            OP_SIDE:
            begin
                upper_next = (dev_reg > 0);
                mag_next   = abs_dev - PULSE_IN_W'(dead_reg);
                throw_next = throw_calc;
            end
            OP_SPAN:
            begin
                span_next = span_calc[SPAN_W-1:0];
                rem_next  = '0;
                cnt_next  = CNT_W'(NUM_W - 1);
                quo_next  = small_throw ? '0 : {prod, {FRAC_BITS{1'b0}}};
            end
            OP_DIV:
            begin
                rem_next = trial_ge ? SPAN_W'(trial - {1'b0, span_reg})
                                    : trial[SPAN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], trial_ge};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_TGT:
            begin
                if (upper_reg)
                    target_next = (up_sum > (NUM_W+1)'({Q_W{1'b1}}))
                                  ? {Q_W{1'b1}} : up_sum[Q_W-1:0];
                else
                    target_next = (quo_reg >= NUM_W'(center_q))
                                  ? '0 : center_q - quo_reg[Q_W-1:0];
            end
            OP_MULA:
            begin
                acc_next = mul_prod;
            end
            OP_MULB:
            begin
                acc_next = acc_reg + mul_prod;
            end
            OP_UPD:
            begin
                smooth_next = blended;
                if (whole < PULSE_IN_W'(OUT_MIN))
                    res_next = OUT_MIN;
                else if (whole > PULSE_IN_W'(OUT_MAX))
                    res_next = OUT_MAX;
                else
                    res_next = whole[PULSE_OUT_W-1:0];
            end
            OP_DEAD:
            begin
                smooth_next = center_q;
                res_next    = center_reg;
            end
            OP_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // center write reloads the smoothed value
        if (cfg_write && (cfg_index == REG_CENTER))
            smooth_next = Q_W'(cfg_data[CENTER_W-1:0]) << FRAC_BITS;
    end

    // control, configuration and smoothed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            out_valid_reg <= 1'b0;
            center_reg    <= CENTER_RESET;
            dead_reg      <= DEAD_RESET;
            gain_reg      <= GAIN_ONE;
            mode_reg      <= 1'b0;
            smooth_reg    <= Q_W'(CENTER_RESET) << FRAC_BITS;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            smooth_reg    <= smooth_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CENTER: center_reg <= cfg_data[CENTER_W-1:0];
                    REG_DEAD:   dead_reg   <= cfg_data[DEAD_W-1:0];
                    REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        pulse_reg    <= pulse_next;
        dev_reg      <= dev_next;
        upper_reg    <= upper_next;
        mag_reg      <= mag_next;
        throw_reg    <= throw_next;
        span_reg     <= span_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        target_reg   <= target_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: tb/tb_pwm_deadband_rescale_ema_unit.sv
// ---------------------------------------------------------------------------
// tb_pwm_deadband_rescale_ema_unit: self-checking bench for the pulse conditioner
// A directed table of register writes and pulse widths, then random pulses
// under a series of register settings and idle and stall patterns. Each accepted
// request is run through a bit-exact deadband, rescale and EMA predictor, and
// every returned pulse width is checked in order against it.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_pwm_deadband_rescale_ema_unit;
    import pdre_pkg::*;

    localparam int          FRAC          = DEF_FRAC_BITS;
    localparam logic [63:0] Q_MAX         = (64'd1 << (12 + FRAC)) - 64'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 120;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          PHASES        = 8;
    localparam int          HALF_ITEMS    = 65;

    typedef enum logic {ROW_WRITE, ROW_PULSE} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     index;
        logic [CFG_DATA_W-1:0]    data;
        logic                     known;
        logic [PULSE_OUT_W-1:0]   pulse;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [PULSE_IN_W-1:0]   pulse_in = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [PULSE_OUT_W-1:0]  pulse_out;

    // predictor copy of the registers and the smoothed value
    logic [CENTER_W-1:0]     cfg_center;
    logic [DEAD_W-1:0]       cfg_dead;
    logic [GAIN_W-1:0]       cfg_gain;
    logic                    cfg_mode;
    logic [63:0]             ema_q;

    logic [PULSE_OUT_W-1:0]  expected_pulses[$];
    stim_row_t               directed_rows[$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int errors    = 0;
    int n_items   = 0;
    int n_results = 0;
    int n_writes  = 0;
    int quiet     = 0;

    pwm_deadband_rescale_ema_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pulse_in  (pulse_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pulse_out (pulse_out)
    );

    // clock
    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // register write as seen by the predictor
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CENTER:
            begin
                cfg_center = data[CENTER_W-1:0];
                ema_q      = 64'(cfg_center) << FRAC;
            end
            REG_DEAD: cfg_dead = data[DEAD_W-1:0];
            REG_GAIN: cfg_gain = data[GAIN_W-1:0];
            REG_MODE: cfg_mode = data[0];
            default: ;
        endcase
    endfunction

    // deadband, side rescale and EMA blend of one pulse width
    function automatic logic [PULSE_OUT_W-1:0] condition_pulse(input logic [PULSE_IN_W-1:0] raw);
        longint      p, c, d, dev, throw_us, span;
        logic [63:0] mag, off, target, g, blended, whole, cq;
        logic        upper;
        p  = longint'(raw);
        c  = longint'(cfg_center);
        d  = longint'(cfg_dead);
        cq = 64'(cfg_center) << FRAC;
        if (cfg_mode && p < c)
            p = c;
        dev = p - c;
        // inside the deadband: output the center and snap the average to it
        if ((cfg_mode && dev <= d) || (!cfg_mode && dev >= -d && dev <= d))
        begin
            ema_q = cq;
            return cfg_center;
        end
        upper    = dev > 0;
        mag      = 64'((upper ? dev : -dev) - d);
        throw_us = upper ? longint'(OUT_MAX) - c : c - longint'(OUT_MIN);
        span     = throw_us - d;
        // a side throw no wider than the deadband leaves no scale
        if (throw_us <= d || span <= 0)
            off = 64'd0;
        else
            off = ((mag * 64'(throw_us)) << FRAC) / 64'(span);
        if (upper)
        begin
            target = cq + off;
            if (target > Q_MAX)
                target = Q_MAX;
        end
        else
            target = (off >= cq) ? 64'd0 : cq - off;
        g = (cfg_gain > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(cfg_gain);
        blended = (g * target + (64'(GAIN_ONE) - g) * ema_q) >> GAIN_SHIFT;
        if (blended > Q_MAX)
            blended = Q_MAX;
        ema_q = blended;
        whole = blended >> FRAC;
        if (whole < 64'(OUT_MIN))
            whole = 64'(OUT_MIN);
        if (whole > 64'(OUT_MAX))
            whole = 64'(OUT_MAX);
        return whole[PULSE_OUT_W-1:0];
    endfunction

    // random pulse: mostly the usable throw, some at the deadband edges, some anywhere
    function automatic logic [PULSE_IN_W-1:0] random_pulse();
        int pick, v, edge_us;
        pick = $urandom_range(99);
        if (pick < 12)
            v = $urandom_range(4095);
        else if (pick < 40)
        begin
            edge_us = int'(cfg_dead) + $urandom_range(4) - 2;
            if (!cfg_mode && $urandom_range(1))
                v = int'(cfg_center) - edge_us;
            else
                v = int'(cfg_center) + edge_us;
        end
        else
            v = $urandom_range(2150, 850);
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[PULSE_IN_W-1:0];
    endfunction

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        directed_rows.push_back('{ROW_WRITE, idx, data[CFG_DATA_W-1:0], 1'b0, '0});
    endtask

    task automatic add_pulse(input int value, input logic known, input int typed);
        directed_rows.push_back('{ROW_PULSE, '0, value[CFG_DATA_W-1:0], known,
                                  typed[PULSE_OUT_W-1:0]});
    endtask

    // offer one request and wait for it to be taken
    task automatic send_pulse(input logic [PULSE_IN_W-1:0] value, input logic known,
                              input logic [PULSE_OUT_W-1:0] typed);
        logic [PULSE_OUT_W-1:0] exp_val;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pulse_in <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        exp_val = condition_pulse(value);
        if (known)
            exp_val = typed;
        expected_pulses.push_back(exp_val);
        n_items++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_pulses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        n_writes++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // one register setting: extremes for the early phases, random after
    task automatic program_setting(input int sel);
        int center, dead, gain, mode;
        case (sel)
            0: begin center = 1500; dead = 0;   gain = 65536;  mode = 0; end
            1: begin center = 1000; dead = 499; gain = 0;      mode = 1; end
            2: begin center = 2000; dead = 511; gain = 131071; mode = 0; end
            3: begin center = 0;    dead = 37;  gain = 1;      mode = 0; end
            4: begin center = 2047; dead = 0;   gain = 40000;  mode = 1; end
            default:
            begin
                center = $urandom_range(2047, 900);
                dead   = $urandom_range(3) == 0 ? $urandom_range(511) : $urandom_range(120);
                gain   = $urandom_range(3) == 0 ? $urandom_range(131071)
                                                : $urandom_range(65536, 2000);
                mode   = $urandom_range(1);
            end
        endcase
        drain();
        // upper data bits beyond each register are don't-care
        write_reg(REG_CENTER, {6'($urandom_range(63)), 11'(center)});
        write_reg(REG_DEAD, {8'($urandom_range(255)), 9'(dead)});
        write_reg(REG_GAIN, 17'(gain));
        write_reg(REG_MODE, {16'($urandom_range(65535)), 1'(mode)});
        write_reg(3'($urandom_range(7, 4)), 17'($urandom_range(131071)));
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            n_results++;
            if (expected_pulses.size() == 0)
            begin
                $error("pulse_out %0d returned with no request outstanding", pulse_out);
                errors++;
            end
            else if (pulse_out !== expected_pulses[0])
            begin
                $error("pulse_out mismatch: expected %0d, actual %0d",
                       expected_pulses[0], pulse_out);
                errors++;
                void'(expected_pulses.pop_front());
            end
            else
                void'(expected_pulses.pop_front());
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // stimulus
    initial
    begin
        apply_reg(REG_CENTER, 17'(CENTER_RESET));
        apply_reg(REG_DEAD, 17'(DEAD_RESET));
        apply_reg(REG_GAIN, GAIN_ONE);
        apply_reg(REG_MODE, 17'd0);

        // defaults after reset, full-gain extremes
        add_pulse(1500, 1'b1, 1500);
        add_pulse(0,    1'b1, 1000);
        add_pulse(4095, 1'b1, 2000);
        add_pulse(1750, 1'b1, 1750);
        add_pulse(1250, 1'b1, 1250);
        // deadband edges and first step past them
        add_write(REG_DEAD, 100);
        add_pulse(1600, 1'b1, 1500);
        add_pulse(1400, 1'b1, 1500);
        add_pulse(1601, 1'b0, 0);
        // gain above one, zero gain, fractional gain
        add_write(REG_GAIN, 131071);
        add_pulse(1900, 1'b0, 0);
        add_write(REG_GAIN, 0);
        add_pulse(2500, 1'b0, 0);
        add_write(REG_GAIN, 16384);
        add_pulse(3000, 1'b0, 0);
        add_pulse(200,  1'b0, 0);
        // bottom-anchored: low side raised to center, one-sided deadband
        add_write(REG_MODE, 1);
        add_pulse(0,    1'b1, 1500);
        add_pulse(1550, 1'b1, 1500);
        add_pulse(4095, 1'b0, 0);
        // upper throw no wider than the deadband
        add_write(REG_CENTER, 2000);
        add_pulse(2500, 1'b1, 2000);
        // lower throw of zero
        add_write(REG_MODE, 0);
        add_write(REG_CENTER, 1000);
        add_pulse(500,  1'b1, 1000);
        // center outside the throw: deadband output is not clamped
        add_write(REG_CENTER, 300);
        add_pulse(300,  1'b1, 300);
        add_pulse(4095, 1'b0, 0);
        add_write(REG_CENTER, 2047);
        add_write(REG_DEAD, 499);
        add_pulse(2047, 1'b1, 2047);
        add_pulse(0,    1'b0, 0);
        // write to an index past the map leaves the registers alone
        add_write(REG_UNUSED, 131071);
        add_pulse(1548, 1'b1, 2047);
        add_write(REG_CENTER, 0);
        add_pulse(1000, 1'b0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
                send_pulse(directed_rows[i].data[PULSE_IN_W-1:0], directed_rows[i].known,
                           directed_rows[i].pulse);
        end

        // random phases over the idle and stall patterns, two settings per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int half = 0; half < 2; half++)
            begin
                program_setting(half == 0 ? ph : 99);
                case (ph % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 75; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 75; end
                    default: begin idle_pct = 28; stall_pct = 28; end
                endcase
                for (int i = 0; i < HALF_ITEMS; i++)
                    send_pulse(random_pulse(), 1'b0, '0);
            end
        end

        // let everything come home, then watch for strays
        in_valid <= 1'b0;
        while (expected_pulses.size() != 0)
            @(posedge clk);
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d pulse requests, %0d results, %0d register writes",
                 n_items, n_results, n_writes);
        $display("settings spanned center, deadband, gain and mode extremes %s",
                 "under four idle patterns");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
